// ===== rtl/shsort_pkg.sv =====
// shared types for the shell sorter: controller command and datapath status bundles
// no dependencies; imported by shsort_ctrl, shsort_dp and the top level
package shsort_pkg;

  localparam int unsigned DATA_W = 32;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // store input element if room, bump count
    logic clr_count;   // end of set
    logic gap_init;    // gap = count / 2, outer = gap
    logic gap_halve;   // gap = gap / 2, outer = gap
    logic rd_outer;    // read store[outer], inner = outer
    logic latch_held;  // held = read data
    logic rd_prev;     // read store[inner - gap]
    logic wr_prev;     // store[inner] = read data, inner -= gap
    logic wr_held;     // store[inner] = held
    logic outer_inc;
    logic k_clr;
    logic rd_k;        // read store[k]
    logic out_load;    // output register = read data
    logic k_inc;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic few;           // fewer than two elements, no pass needed
    logic halved_zero;   // next gap would be zero
    logic outer_lt_n;
    logic inner_ge_gap;
    logic prev_gt_held;  // signed compare of read data against held value
    logic k_is_last;
  } sts_t;

endpackage

// ===== rtl/shsort_dp.sv =====
// shell sorter datapath: element store, count, gap and index registers, output register
// depends on shsort_pkg for the command and status bundles
module shsort_dp #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  shsort_pkg::cmd_t                    cmd_i,
  output shsort_pkg::sts_t                    sts_o,
  input  logic signed [shsort_pkg::DATA_W-1:0] element_value_i,
  output logic signed [shsort_pkg::DATA_W-1:0] sorted_value_o,
  output logic                                last_out_o
);
  import shsort_pkg::*;

  localparam int unsigned IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);

  logic [DATA_W-1:0] mem_q [MAX_ELEMENTS];
  logic [DATA_W-1:0] rdata_q;
  logic [DATA_W-1:0] held_q;
  logic [DATA_W-1:0] out_data_q;
  logic              out_last_q;

  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] gap_q, gap_d;
  logic [CNT_W-1:0] outer_q, outer_d;
  logic [IDX_W-1:0] inner_q, inner_d;
  logic [IDX_W-1:0] k_q, k_d;

  logic              full;
  logic [IDX_W-1:0]  gap_half;
  logic [IDX_W-1:0]  gap_first;
  logic [IDX_W-1:0]  prev_idx;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] wdata;
  logic              re;
  logic [IDX_W-1:0]  raddr;

  assign full      = (count_q == CNT_W'(MAX_ELEMENTS));
  assign gap_half  = gap_q >> 1;
  assign gap_first = IDX_W'(count_q >> 1);
  assign prev_idx  = inner_q - gap_q;

  // write port select
  always_comb begin
    we    = 1'b0;
    waddr = inner_q;
    wdata = held_q;
    if (cmd_i.load && !full) begin
      we    = 1'b1;
      waddr = count_q[IDX_W-1:0];
      wdata = element_value_i;
    end else if (cmd_i.wr_prev) begin
      we    = 1'b1;
      wdata = rdata_q;
    end else if (cmd_i.wr_held) begin
      we    = 1'b1;
    end
  end

  // read port select
  always_comb begin
    re    = cmd_i.rd_outer | cmd_i.rd_prev | cmd_i.rd_k;
    raddr = k_q;
    if (cmd_i.rd_outer) begin
      raddr = outer_q[IDX_W-1:0];
    end else if (cmd_i.rd_prev) begin
      raddr = prev_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_comb begin
    count_d = count_q;
    gap_d   = gap_q;
    outer_d = outer_q;
    inner_d = inner_q;
    k_d     = k_q;
    if (cmd_i.load && !full) count_d = count_q + CNT_W'(1);
    if (cmd_i.clr_count)     count_d = '0;
    if (cmd_i.gap_init) begin
      gap_d   = gap_first;
      outer_d = CNT_W'(gap_first);
    end
    if (cmd_i.gap_halve) begin
      gap_d   = gap_half;
      outer_d = CNT_W'(gap_half);
    end
    if (cmd_i.outer_inc) outer_d = outer_q + CNT_W'(1);
    if (cmd_i.rd_outer)  inner_d = outer_q[IDX_W-1:0];
    if (cmd_i.wr_prev)   inner_d = prev_idx;
    if (cmd_i.k_clr)     k_d = '0;
    if (cmd_i.k_inc)     k_d = k_q + IDX_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      gap_q   <= '0;
      outer_q <= '0;
      inner_q <= '0;
      k_q     <= '0;
    end else begin
      count_q <= count_d;
      gap_q   <= gap_d;
      outer_q <= outer_d;
      inner_q <= inner_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_held) begin
      held_q <= rdata_q;
    end
    if (cmd_i.out_load) begin
      out_data_q <= rdata_q;
      out_last_q <= sts_o.k_is_last;
    end
  end

  always_comb begin
    sts_o.few          = (count_q < CNT_W'(2));
    sts_o.halved_zero  = (gap_half == '0);
    sts_o.outer_lt_n   = (outer_q < count_q);
    sts_o.inner_ge_gap = (inner_q >= gap_q);
    sts_o.prev_gt_held = ($signed(rdata_q) > $signed(held_q));
    sts_o.k_is_last    = ((CNT_W'(k_q) + CNT_W'(1)) == count_q);
  end

  assign sorted_value_o = out_data_q;
  assign last_out_o     = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ELEMENTS))
    else $error("element count beyond store depth");

  a_outer_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_outer |-> (outer_q < count_q) && (gap_q != '0))
    else $error("outer read outside the held elements");

  a_prev_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_prev |-> (inner_q >= gap_q) && (gap_q != '0) && (CNT_W'(inner_q) < count_q))
    else $error("gapped read below the store base");

endmodule

// ===== rtl/shsort_ctrl.sv =====
// shell sorter controller: sequences load, gapped insertion passes and output burst
// depends on shsort_pkg; drives commands into shsort_dp and reads its status
module shsort_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             is_last_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  shsort_pkg::sts_t sts_i,
  output shsort_pkg::cmd_t cmd_o
);
  import shsort_pkg::*;

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_GAP_INIT = 4'd1;
  localparam logic [3:0] S_RD_OUTER = 4'd2;
  localparam logic [3:0] S_HOLD     = 4'd3;
  localparam logic [3:0] S_CHK      = 4'd4;
  localparam logic [3:0] S_CMP      = 4'd5;
  localparam logic [3:0] S_OUT_RD   = 4'd6;
  localparam logic [3:0] S_OUT_LD   = 4'd7;
  localparam logic [3:0] S_OUT_HOLD = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (is_last_i) state_d = S_GAP_INIT;
        end
      end
      S_GAP_INIT: begin
        cmd_o.gap_init = 1'b1;
        if (sts_i.few) begin
          cmd_o.k_clr = 1'b1;
          state_d     = S_OUT_RD;
        end else begin
          state_d = S_RD_OUTER;
        end
      end
      S_RD_OUTER: begin
        if (sts_i.outer_lt_n) begin
          cmd_o.rd_outer = 1'b1;
          state_d        = S_HOLD;
        end else if (sts_i.halved_zero) begin
          cmd_o.k_clr = 1'b1;
          state_d     = S_OUT_RD;
        end else begin
          cmd_o.gap_halve = 1'b1;
        end
      end
      S_HOLD: begin
        cmd_o.latch_held = 1'b1;
        state_d          = S_CHK;
      end
      S_CHK: begin
        if (sts_i.inner_ge_gap) begin
          cmd_o.rd_prev = 1'b1;
          state_d       = S_CMP;
        end else begin
          cmd_o.wr_held   = 1'b1;
          cmd_o.outer_inc = 1'b1;
          state_d         = S_RD_OUTER;
        end
      end
      S_CMP: begin
        // shift the larger neighbor up one gap, or drop the held value in place
        if (sts_i.prev_gt_held) begin
          cmd_o.wr_prev = 1'b1;
          state_d       = S_CHK;
        end else begin
          cmd_o.wr_held   = 1'b1;
          cmd_o.outer_inc = 1'b1;
          state_d         = S_RD_OUTER;
        end
      end
      S_OUT_RD: begin
        cmd_o.rd_k = 1'b1;
        state_d    = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd_o.out_load = 1'b1;
        state_d        = S_OUT_HOLD;
      end
      S_OUT_HOLD: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.k_is_last) begin
            cmd_o.clr_count = 1'b1;
            state_d         = S_LOAD;
          end else begin
            cmd_o.k_inc = 1'b1;
            state_d     = S_OUT_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  a_cmp_after_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> ($past(state_q) == S_CHK))
    else $error("compare step without a preceding read");

  a_out_ld_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT_LD) |-> ($past(state_q) == S_OUT_RD))
    else $error("output load without a store read");

  a_sort_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GAP_INIT) |-> ($past(state_q) == S_LOAD) && $past(in_valid_i && is_last_i))
    else $error("sort started without a last element");

endmodule

// ===== rtl/shell_sorter_halving_gaps.sv =====
// shell sorter, gaps n/2, n/4 .. 1, over a single-port-read element store.
// load: one element per cycle. sort: a setup step, then per outer step a store read,
// a latch of the held value and a check; per shifted element a gapped read and a compare;
// one more compare where the walk stops; a gap halving per pass end. output: each result
// is read, registered and held until out_ready_i; input is held off until the burst is done.
// reset clears the controller and counters only; the store is not cleared.
module shell_sorter_halving_gaps #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [shsort_pkg::DATA_W-1:0] element_value_i,
  input  logic                                 is_last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [shsort_pkg::DATA_W-1:0] sorted_value_o,
  output logic                                 last_out_o
);
  import shsort_pkg::*;

  cmd_t cmd;
  sts_t sts;

  shsort_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .is_last_i   (is_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  shsort_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .element_value_i (element_value_i),
    .sorted_value_o  (sorted_value_o),
    .last_out_o      (last_out_o)
  );

endmodule
